### rtl/core/dfsc_pkg.sv
// ----------------------------------------------------------------------------
// dfsc_pkg
// Shared types and constants of the depth frame stance classifier.
// ----------------------------------------------------------------------------
package dfsc_pkg;

   localparam int DEPTH_W         = 15;
   localparam int CNT_CFG_W       = 7;
   localparam int TRIM_W          = 7;
   localparam int HINT_W          = 2;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 15;
   localparam int FRAME_CELLS_DEF = 64;
   localparam int TRIM_SHIFT      = 8;

   localparam logic [DEPTH_W-1:0] MIN_SLOP   = DEPTH_W'(50);
   localparam int                 MIN_TRIM_N = 6;
   localparam int                 MIN_SLICE  = 3;

   localparam logic [HINT_W-1:0] HINT_NONE  = 2'd0;
   localparam logic [HINT_W-1:0] HINT_CLOSE = 2'd1;
   localparam logic [HINT_W-1:0] HINT_FAR   = 2'd2;
   localparam logic [HINT_W-1:0] HINT_OK    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BAND_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_MIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_MAX  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALID  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BAND   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIM       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOP       = 3'd7;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_PREP,
      ST_SELECT,
      ST_SCAN,
      ST_DECIDE,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic collect_en;
      logic prep;
      logic select;
      logic scan;
      logic decide;
      logic finish;
   } dfsc_cmd_type;

   typedef struct packed {
      logic frame_end;
      logic n_zero;
      logic issue_done;
      logic bit_last;
      logic out_free;
   } dfsc_status_type;

endpackage

### rtl/core/dfsc_ctrl.sv
// ----------------------------------------------------------------------------
// dfsc_ctrl
// Sequencer: frame collection, order-statistic search passes, result load.
// ----------------------------------------------------------------------------
module dfsc_ctrl
   import dfsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  dfsc_status_type status,
   output dfsc_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (status.frame_end) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_SELECT;
         end
         ST_SELECT: begin
            state_in = status.n_zero ? ST_FINISH : ST_SCAN;
         end
         ST_SCAN: begin
            if (status.issue_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = status.bit_last ? ST_FINISH : ST_SCAN;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_COLLECT;
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_COLLECT: cmd.collect_en = 1'b1;
         ST_PREP:    cmd.prep       = 1'b1;
         ST_SELECT:  cmd.select     = 1'b1;
         ST_SCAN:    cmd.scan       = 1'b1;
         ST_DECIDE:  cmd.decide     = 1'b1;
         ST_FINISH:  cmd.finish     = status.out_free;
         default:    cmd            = '0;
      endcase
   end

endmodule

### rtl/core/dfsc_dp.sv
// ----------------------------------------------------------------------------
// dfsc_dp
// Datapath: config registers, cell store, counters, bitwise order-statistic
// search over the store, classification and the result register.
// ----------------------------------------------------------------------------
module dfsc_dp
   import dfsc_pkg::*;
#(
   parameter int FRAME_CELLS = FRAME_CELLS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  dfsc_cmd_type          cmd,
   output dfsc_status_type       status,
   input  logic                  in_accept,
   input  logic [DEPTH_W-1:0]    req_depth,
   input  logic                  req_last_cell,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [HINT_W-1:0]     rsp_hint,
   output logic [DEPTH_W-1:0]    rsp_median_depth,
   output logic [DEPTH_W-1:0]    rsp_stance_depth,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW   = $clog2(FRAME_CELLS + 1);
   localparam int AW   = $clog2(FRAME_CELLS);
   localparam int CMPW = (CW > CNT_CFG_W) ? CW : CNT_CFG_W;
   localparam int PW   = CW + TRIM_W;
   localparam int SW   = CW + 2;
   localparam int BW   = $clog2(DEPTH_W);
   localparam logic [CW-1:0] CELLS_MAX = CW'(FRAME_CELLS);

   // configuration
   logic [DEPTH_W-1:0]   band_min_ff, band_max_ff, valid_min_ff, valid_max_ff, slop_ff;
   logic [CNT_CFG_W-1:0] min_valid_ff, min_band_ff;
   logic [TRIM_W-1:0]    trim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_min_ff  <= DEPTH_W'(300);
         band_max_ff  <= DEPTH_W'(1500);
         valid_min_ff <= DEPTH_W'(0);
         valid_max_ff <= DEPTH_W'(4000);
         min_valid_ff <= CNT_CFG_W'(8);
         min_band_ff  <= CNT_CFG_W'(4);
         trim_ff      <= TRIM_W'(26);
         slop_ff      <= DEPTH_W'(100);
      end else if (csr_write) begin
         case (csr_index)
            CSR_BAND_MIN:  band_min_ff  <= csr_wdata[DEPTH_W-1:0];
            CSR_BAND_MAX:  band_max_ff  <= csr_wdata[DEPTH_W-1:0];
            CSR_VALID_MIN: valid_min_ff <= csr_wdata[DEPTH_W-1:0];
            CSR_VALID_MAX: valid_max_ff <= csr_wdata[DEPTH_W-1:0];
            CSR_MIN_VALID: min_valid_ff <= csr_wdata[CNT_CFG_W-1:0];
            CSR_MIN_BAND:  min_band_ff  <= csr_wdata[CNT_CFG_W-1:0];
            CSR_TRIM:      trim_ff      <= csr_wdata[TRIM_W-1:0];
            CSR_SLOP:      slop_ff      <= csr_wdata[DEPTH_W-1:0];
            default:       ;
         endcase
      end
   end

   // frame collection
   logic [CW-1:0] cell_cnt_ff, cell_cnt_in;
   logic [CW-1:0] valid_cnt_ff, valid_cnt_in;
   logic [CW-1:0] band_cnt_ff, band_cnt_in;
   logic          take, valid_hit, band_hit, wr_en;

   assign take      = in_accept && (cell_cnt_ff < CELLS_MAX);
   assign valid_hit = (req_depth > valid_min_ff) && (req_depth < valid_max_ff);
   assign band_hit  = (req_depth > band_min_ff) && (req_depth < band_max_ff);
   assign wr_en     = take && valid_hit;

   always_comb begin
      cell_cnt_in  = cell_cnt_ff;
      valid_cnt_in = valid_cnt_ff;
      band_cnt_in  = band_cnt_ff;
      if (take) begin
         cell_cnt_in = cell_cnt_ff + CW'(1);
         if (valid_hit) valid_cnt_in = valid_cnt_ff + CW'(1);
         if (band_hit)  band_cnt_in  = band_cnt_ff + CW'(1);
      end
      // start the next frame once the result is loaded
      if (cmd.finish) begin
         cell_cnt_in  = '0;
         valid_cnt_in = '0;
         band_cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_cnt_ff  <= '0;
         valid_cnt_ff <= '0;
         band_cnt_ff  <= '0;
      end else begin
         cell_cnt_ff  <= cell_cnt_in;
         valid_cnt_ff <= valid_cnt_in;
         band_cnt_ff  <= band_cnt_in;
      end
   end

   // cell store
   logic [DEPTH_W-1:0] store_mem [FRAME_CELLS];
   logic [DEPTH_W-1:0] rd_q_ff;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               rd_en;
   logic               rd_vld_ff;

   assign rd_en = cmd.scan && (idx_ff != valid_cnt_ff);

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[valid_cnt_ff[AW-1:0]] <= req_depth;
      if (rd_en) rd_q_ff <= store_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
      end
   end

   // trim setup
   logic [CMPW-1:0] n_ext, band_ext, minv_ext, minb_ext;
   logic [PW-1:0]   prod;
   logic [CW-1:0]   cut_raw, cut_ff;
   logic            elig_ff;

   assign n_ext    = CMPW'(valid_cnt_ff);
   assign band_ext = CMPW'(band_cnt_ff);
   assign minv_ext = CMPW'(min_valid_ff);
   assign minb_ext = CMPW'(min_band_ff);
   assign prod     = PW'(valid_cnt_ff) * PW'(trim_ff);
   assign cut_raw  = CW'(prod >> TRIM_SHIFT);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         cut_ff  <= (cut_raw == '0) ? CW'(1) : cut_raw;
         elig_ff <= (n_ext >= minv_ext) && (band_ext >= minb_ext)
                    && (n_ext >= CMPW'(MIN_TRIM_N));
      end
   end

   logic signed [SW-1:0] slice, slice_half;
   logic                 trim_ok;
   logic [CW-1:0]        k_sel;

   assign slice      = $signed({2'b00, valid_cnt_ff}) - $signed({1'b0, cut_ff, 1'b0});
   assign slice_half = (slice - SW'(1)) >>> 1;
   assign trim_ok    = elig_ff && (slice >= SW'(MIN_SLICE));
   assign k_sel      = trim_ok ? (cut_ff + slice_half[CW-1:0])
                               : ((valid_cnt_ff - CW'(1)) >> 1);

   // search: build the answer one bit at a time, MSB first; each pass counts
   // the stored cells below the trial value
   logic [CW-1:0]      k_ff, cnt_ff, cnt_in;
   logic               trim_ok_ff;
   logic [DEPTH_W-1:0] v_ff, v_in, bit_mask, low_mask, thr;
   logic [BW-1:0]      bit_ff, bit_in;

   assign bit_mask = DEPTH_W'(1) << bit_ff;
   assign low_mask = bit_mask - DEPTH_W'(1);
   assign thr      = v_ff | low_mask;

   always_comb begin
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      v_in   = v_ff;
      bit_in = bit_ff;
      if (rd_en) idx_in = idx_ff + CW'(1);
      if (rd_vld_ff && (rd_q_ff <= thr)) cnt_in = cnt_ff + CW'(1);
      if (cmd.select) begin
         idx_in = '0;
         cnt_in = '0;
         v_in   = '0;
         bit_in = BW'(DEPTH_W - 1);
      end
      if (cmd.decide) begin
         if (cnt_ff <= k_ff) v_in = v_ff | bit_mask;
         bit_in = bit_ff - BW'(1);
         idx_in = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      v_ff   <= v_in;
      bit_ff <= bit_in;
      if (cmd.select) begin
         k_ff       <= k_sel;
         trim_ok_ff <= trim_ok;
      end
   end

   // classification
   logic [DEPTH_W:0]       band_sum;
   logic [DEPTH_W-1:0]     centre, slop;
   logic signed [DEPTH_W+1:0] lo_lim, hi_lim, s_val;
   logic [HINT_W-1:0]      hint_cls;

   assign band_sum = {1'b0, band_min_ff} + {1'b0, band_max_ff};
   assign centre   = band_sum[DEPTH_W:1];
   assign slop     = (slop_ff < MIN_SLOP) ? MIN_SLOP : slop_ff;
   assign lo_lim   = $signed({2'b00, centre}) - $signed({2'b00, slop});
   assign hi_lim   = $signed({2'b00, centre}) + $signed({2'b00, slop});
   assign s_val    = $signed({2'b00, v_ff});

   always_comb begin
      if (!trim_ok_ff)               hint_cls = HINT_NONE;
      else if (v_ff < band_min_ff)   hint_cls = HINT_CLOSE;
      else if (v_ff > band_max_ff)   hint_cls = HINT_FAR;
      else if (s_val < lo_lim)       hint_cls = HINT_CLOSE;
      else if (s_val > hi_lim)       hint_cls = HINT_FAR;
      else                           hint_cls = HINT_OK;
   end

   // result register
   logic               rsp_valid_ff;
   logic [HINT_W-1:0]  hint_ff;
   logic [DEPTH_W-1:0] median_ff, stance_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         hint_ff   <= (valid_cnt_ff == '0) ? HINT_NONE : hint_cls;
         median_ff <= (valid_cnt_ff == '0) ? '0 : v_ff;
         stance_ff <= (trim_ok_ff && (valid_cnt_ff != '0)) ? v_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hint         = hint_ff;
   assign rsp_median_depth = median_ff;
   assign rsp_stance_depth = stance_ff;

   assign status.frame_end  = in_accept && req_last_cell;
   assign status.n_zero     = (valid_cnt_ff == '0);
   assign status.issue_done = (idx_ff == valid_cnt_ff);
   assign status.bit_last   = (bit_ff == '0);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

### rtl/core/depth_frame_stance_classifier_top.sv
// ----------------------------------------------------------------------------
// depth_frame_stance_classifier_top
// Per-frame presence and distance classifier over a stream of depth cells.
// ----------------------------------------------------------------------------
// Cells are taken one per clock while a frame is collected. After the cell
// marked last_cell the input stalls while the median is found by a bitwise
// search over the cell store: 15 passes, each reading the n stored valid
// cells through the single store read port, then letting the last read land
// and deciding the bit; with no valid cells the passes are skipped (n = valid
// cells, at most FRAME_CELLS). The stall also covers any wait for the output
// register to free. The result sits in an output register, so collection of
// the next frame resumes while it waits to be taken. Configuration writes are
// always ready.
module depth_frame_stance_classifier_top
   import dfsc_pkg::*;
#(
   parameter int FRAME_CELLS = FRAME_CELLS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DEPTH_W-1:0]    req_depth,
   input  logic                  req_last_cell,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [HINT_W-1:0]     rsp_hint,
   output logic [DEPTH_W-1:0]    rsp_median_depth,
   output logic [DEPTH_W-1:0]    rsp_stance_depth,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dfsc_cmd_type    cmd;
   dfsc_status_type status;
   logic            in_accept;

   assign req_stall = !cmd.collect_en;
   assign in_accept = req_valid && cmd.collect_en;
   assign csr_ready = 1'b1;

   dfsc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   dfsc_dp #(
      .FRAME_CELLS (FRAME_CELLS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .in_accept        (in_accept),
      .req_depth        (req_depth),
      .req_last_cell    (req_last_cell),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_hint         (rsp_hint),
      .rsp_median_depth (rsp_median_depth),
      .rsp_stance_depth (rsp_stance_depth),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

### rtl/core/dfsc_checker.sv
// ----------------------------------------------------------------------------
// dfsc_checker
// Port-level checks of the stance classifier, bound to the top level.
// ----------------------------------------------------------------------------
module dfsc_checker
   import dfsc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_last_cell,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [HINT_W-1:0]  rsp_hint,
   input logic [DEPTH_W-1:0] rsp_median_depth,
   input logic [DEPTH_W-1:0] rsp_stance_depth
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hint)
         && $stable(rsp_median_depth) && $stable(rsp_stance_depth))
      else $error("stalled result changed");

   // no person means no stance depth
   a_no_stance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hint == HINT_NONE) |-> rsp_stance_depth == '0)
      else $error("stance depth without a person");

   // a person result reports the trimmed median in both fields
   a_same_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hint != HINT_NONE) |-> rsp_median_depth == rsp_stance_depth)
      else $error("median and stance differ for a person");

   // the frame end item starts the search, so input stalls next
   a_end_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_cell |=> req_stall)
      else $error("input not stalled after frame end");

endmodule

bind depth_frame_stance_classifier_top dfsc_checker u_dfsc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last_cell    (req_last_cell),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hint         (rsp_hint),
   .rsp_median_depth (rsp_median_depth),
   .rsp_stance_depth (rsp_stance_depth)
);
